// ===== hw/rtl/trs_pkg.sv =====
// Shared types, constants and rounding function for the TRS-to-matrix pipeline.
// No dependencies; imported by every module under hw/rtl.
package trs_pkg;

	typedef logic signed [15:0] quat_t;   // Q2.14
	typedef logic signed [15:0] scale_t;  // Q8.8
	typedef logic signed [31:0] q16_t;    // Q16.16
	typedef logic signed [31:0] prod_t;   // Q4.28 quaternion product
	typedef logic signed [33:0] term_t;   // Q.28 rotation term
	typedef logic signed [49:0] scaled_t; // Q.36 scaled term
	typedef logic signed [50:0] rnd_t;

	localparam int unsigned NUM_ENT = 9;
	localparam int unsigned NUM_AXIS = 3;

	localparam term_t ONE_Q28  = term_t'(1) <<< 28;
	localparam rnd_t  RND_HALF = rnd_t'(1) <<< 19;

	typedef struct packed {
		prod_t xx;
		prod_t xy;
		prod_t xz;
		prod_t xw;
		prod_t yy;
		prod_t yz;
		prod_t yw;
		prod_t zz;
		prod_t zw;
	} quat_prod_t;

	typedef term_t   term_arr_t   [NUM_ENT];
	typedef scaled_t scaled_arr_t [NUM_ENT];
	typedef q16_t    q16_arr_t    [NUM_ENT];
	typedef scale_t  scale_arr_t  [NUM_AXIS];

	// Q.36 -> Q16.16, round half up. |p| <= 2^47, so the result always fits
	// in 31 bits and the saturation bound is never reached.
	function automatic q16_t round_q16(scaled_t p);
		rnd_t t;
		t = rnd_t'(p) + RND_HALF;
		return q16_t'(t >>> 20);
	endfunction

endpackage

// ===== hw/rtl/trs_quat_prod.sv =====
// Stage 1: the nine pairwise quaternion products, plus scale capture.
// Depends on trs_pkg.
module trs_quat_prod import trs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       vld_in,
	input  quat_t      qx,
	input  quat_t      qy,
	input  quat_t      qz,
	input  quat_t      qw,
	input  scale_arr_t scale_in,
	output logic       vld_s1,
	output quat_prod_t prod_s1,
	output scale_arr_t scale_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_in) begin
			prod_s1.xx <= prod_t'(qx) * prod_t'(qx);
			prod_s1.xy <= prod_t'(qx) * prod_t'(qy);
			prod_s1.xz <= prod_t'(qx) * prod_t'(qz);
			prod_s1.xw <= prod_t'(qx) * prod_t'(qw);
			prod_s1.yy <= prod_t'(qy) * prod_t'(qy);
			prod_s1.yz <= prod_t'(qy) * prod_t'(qz);
			prod_s1.yw <= prod_t'(qy) * prod_t'(qw);
			prod_s1.zz <= prod_t'(qz) * prod_t'(qz);
			prod_s1.zw <= prod_t'(qz) * prod_t'(qw);
			scale_s1   <= scale_in;
		end
	end

endmodule

// ===== hw/rtl/trs_rot_term.sv =====
// Stage 2: combines products into the nine Q.28 rotation terms.
// Depends on trs_pkg.
module trs_rot_term import trs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       vld_in,
	input  quat_prod_t prod,
	input  scale_arr_t scale_in,
	output logic       vld_s2,
	output term_arr_t  term_s2,
	output scale_arr_t scale_s2
);

	term_arr_t term_d;

	// Products widen to 34 bits before summing; doubled sums reach +-2^32.
	always_comb begin
		term_d[0] = ONE_Q28 - ((term_t'(prod.yy) + term_t'(prod.zz)) <<< 1);
		term_d[1] = (term_t'(prod.xy) + term_t'(prod.zw)) <<< 1;
		term_d[2] = (term_t'(prod.xz) - term_t'(prod.yw)) <<< 1;
		term_d[3] = (term_t'(prod.xy) - term_t'(prod.zw)) <<< 1;
		term_d[4] = ONE_Q28 - ((term_t'(prod.xx) + term_t'(prod.zz)) <<< 1);
		term_d[5] = (term_t'(prod.yz) + term_t'(prod.xw)) <<< 1;
		term_d[6] = (term_t'(prod.xz) + term_t'(prod.yw)) <<< 1;
		term_d[7] = (term_t'(prod.yz) - term_t'(prod.xw)) <<< 1;
		term_d[8] = ONE_Q28 - ((term_t'(prod.xx) + term_t'(prod.yy)) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_in) begin
			term_s2  <= term_d;
			scale_s2 <= scale_in;
		end
	end

endmodule

// ===== hw/rtl/trs_scale_mul.sv =====
// Stage 3: multiplies each rotation term by its row's scale (Q.36).
// Depends on trs_pkg.
module trs_scale_mul import trs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  term_arr_t   term,
	input  scale_arr_t  scale_in,
	output logic        vld_s3,
	output scaled_arr_t scaled_s3
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_in;
		end
	end

	for (genvar i = 0; i < NUM_ENT; i++) begin : g_ent
		// row i/3 takes scale axis i/3
		always_ff @(posedge clk) begin
			if (en && vld_in) begin
				scaled_s3[i] <= scaled_t'(term[i]) * scaled_t'(scale_in[i / NUM_AXIS]);
			end
		end
	end

endmodule

// ===== hw/rtl/trs_round_sat.sv =====
// Stage 4: rounds Q.36 entries to Q16.16 into the output register.
// Depends on trs_pkg.
module trs_round_sat import trs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  scaled_arr_t scaled,
	output logic        vld_s4,
	output q16_arr_t    ent_s4
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_in;
		end
	end

	for (genvar i = 0; i < NUM_ENT; i++) begin : g_ent
		always_ff @(posedge clk) begin
			if (en && vld_in) begin
				ent_s4[i] <= round_q16(scaled[i]);
			end
		end
	end

endmodule

// ===== hw/rtl/trs_transform_to_matrix.sv =====
// Top level: quaternion, scale and translation to affine matrix rows 0..3.
// Depends on trs_pkg, trs_quat_prod, trs_rot_term, trs_scale_mul, trs_round_sat.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   quat_x..w, scale_x..z, trans_x..z
//  out      out_valid / out_ready m00..m22, m30..m32
//
// Four register stages: products, rotation terms, scale multiply, rounding
// into the output register. One transaction per cycle while the output is not stalled.
// All stages advance together while the output register is empty or taken,
// so a stall freezes the whole pipe in place and in_ready follows it.
// Reset clears the stage valid bits only.
module trs_transform_to_matrix import trs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  quat_t quat_x,
	input  quat_t quat_y,
	input  quat_t quat_z,
	input  quat_t quat_w,
	input  scale_t scale_x,
	input  scale_t scale_y,
	input  scale_t scale_z,
	input  q16_t  trans_x,
	input  q16_t  trans_y,
	input  q16_t  trans_z,
	output logic  out_valid,
	input  logic  out_ready,
	output q16_t  m00,
	output q16_t  m01,
	output q16_t  m02,
	output q16_t  m10,
	output q16_t  m11,
	output q16_t  m12,
	output q16_t  m20,
	output q16_t  m21,
	output q16_t  m22,
	output q16_t  m30,
	output q16_t  m31,
	output q16_t  m32
);

	logic        adv;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	scale_arr_t  scale_in, scale_s1, scale_s2;
	quat_prod_t  prod_s1;
	term_arr_t   term_s2;
	scaled_arr_t scaled_s3;
	q16_arr_t    ent_s4;
	q16_t        tx_s1, ty_s1, tz_s1;
	q16_t        tx_s2, ty_s2, tz_s2;
	q16_t        tx_s3, ty_s3, tz_s3;
	q16_t        tx_s4, ty_s4, tz_s4;

	assign adv      = !vld_s4 || out_ready;
	assign in_ready = adv;

	assign scale_in[0] = scale_x;
	assign scale_in[1] = scale_y;
	assign scale_in[2] = scale_z;

	trs_quat_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (in_valid),
		.qx       (quat_x),
		.qy       (quat_y),
		.qz       (quat_z),
		.qw       (quat_w),
		.scale_in (scale_in),
		.vld_s1   (vld_s1),
		.prod_s1  (prod_s1),
		.scale_s1 (scale_s1)
	);

	trs_rot_term u_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s1),
		.prod     (prod_s1),
		.scale_in (scale_s1),
		.vld_s2   (vld_s2),
		.term_s2  (term_s2),
		.scale_s2 (scale_s2)
	);

	trs_scale_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.vld_in    (vld_s2),
		.term      (term_s2),
		.scale_in  (scale_s2),
		.vld_s3    (vld_s3),
		.scaled_s3 (scaled_s3)
	);

	trs_round_sat u_rnd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_in (vld_s3),
		.scaled (scaled_s3),
		.vld_s4 (vld_s4),
		.ent_s4 (ent_s4)
	);

	// translation rides alongside the arithmetic stages
	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_valid) begin
				tx_s1 <= trans_x;
				ty_s1 <= trans_y;
				tz_s1 <= trans_z;
			end
			if (vld_s1) begin
				tx_s2 <= tx_s1;
				ty_s2 <= ty_s1;
				tz_s2 <= tz_s1;
			end
			if (vld_s2) begin
				tx_s3 <= tx_s2;
				ty_s3 <= ty_s2;
				tz_s3 <= tz_s2;
			end
			if (vld_s3) begin
				tx_s4 <= tx_s3;
				ty_s4 <= ty_s3;
				tz_s4 <= tz_s3;
			end
		end
	end

	assign out_valid = vld_s4;
	assign m00 = ent_s4[0];
	assign m01 = ent_s4[1];
	assign m02 = ent_s4[2];
	assign m10 = ent_s4[3];
	assign m11 = ent_s4[4];
	assign m12 = ent_s4[5];
	assign m20 = ent_s4[6];
	assign m21 = ent_s4[7];
	assign m22 = ent_s4[8];
	assign m30 = tx_s4;
	assign m31 = ty_s4;
	assign m32 = tz_s4;

endmodule
